>>> design/gha_pkg.sv
// gha_pkg: shared types, field widths and codes of the generational handle allocator
// no dependencies; used by gha_ctrl, gha_datapath and generational_handle_allocator
package gha_pkg;

	localparam int IDX_W = 10;
	localparam int GEN_W = 8;

	localparam int DEF_CAPACITY = 1024;
	localparam int DEF_GEN_BITS = 8;

	localparam logic [1:0] KIND_CREATE = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_STALE = 2'd2;

	typedef struct packed {
		logic [1:0]       kind;
		logic [IDX_W-1:0] entity_index;
		logic [GEN_W-1:0] entity_generation;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] result_index;
		logic [GEN_W-1:0] result_generation;
		logic             alive;
		logic [1:0]       status;
	} result_t;

	typedef struct packed {
		logic capture;
		logic exec;
	} ctrl_cmd_t;

endpackage

>>> design/gha_ctrl.sv
// gha_ctrl: two-state sequencer of the handle allocator (capture and read, then execute)
// depends on gha_pkg for the command struct
module gha_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output gha_pkg::ctrl_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic done_q;

	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && start;
		cmd.exec    = (state_q == ST_EXEC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q == ST_EXEC);
	assign done = done_q;

endmodule

>>> design/gha_datapath.sv
// gha_datapath: slot memory, free list registers, alive check and result register
// depends on gha_pkg; driven by the commands of gha_ctrl
module gha_datapath #(
	parameter int CAPACITY = gha_pkg::DEF_CAPACITY,
	parameter int GEN_BITS = gha_pkg::DEF_GEN_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gha_pkg::ctrl_cmd_t cmd,
	input  gha_pkg::item_t     item,
	output gha_pkg::result_t   result
);

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int CW = (LW > gha_pkg::IDX_W) ? LW : gha_pkg::IDX_W;
	localparam logic [LW-1:0] NONE = LW'(CAPACITY);

	logic [LW-1:0]       link_mem [CAPACITY];
	logic [GEN_BITS-1:0] gen_mem  [CAPACITY];

	logic [LW-1:0]       used_q;
	logic [LW-1:0]       free_head_q;
	logic [LW-1:0]       free_cnt_q;

	gha_pkg::item_t      item_s1;
	logic [LW-1:0]       rd_link_s1;
	logic [GEN_BITS-1:0] rd_gen_s1;
	gha_pkg::result_t    result_q;

	logic                reuse;
	logic [IW-1:0]       rd_addr;
	logic                alive;
	logic                we;
	logic [IW-1:0]       wr_addr;
	logic [LW-1:0]       wr_link;
	logic [GEN_BITS-1:0] wr_gen;
	logic [GEN_BITS-1:0] next_gen;
	gha_pkg::result_t    res_d;

	// free list usable only when nonempty and the head names a real slot
	assign reuse = (free_cnt_q != '0) && (free_head_q < NONE);

	always_comb begin
		if (item.kind == gha_pkg::KIND_CREATE) begin
			rd_addr = IW'(free_head_q);
		end else begin
			rd_addr = IW'(item.entity_index);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_s1    <= item;
			rd_link_s1 <= link_mem[rd_addr];
			rd_gen_s1  <= gen_mem[rd_addr];
		end
	end

	assign alive = (CW'(item_s1.entity_index) < CW'(used_q))
		&& (CW'(rd_link_s1) == CW'(item_s1.entity_index))
		&& (rd_gen_s1 == GEN_BITS'(item_s1.entity_generation));

	assign next_gen = rd_gen_s1 + 1'b1;

	always_comb begin
		we                      = 1'b0;
		wr_addr                 = IW'(item_s1.entity_index);
		wr_link                 = rd_link_s1;
		wr_gen                  = rd_gen_s1;
		res_d.result_index      = item_s1.entity_index;
		res_d.result_generation = item_s1.entity_generation;
		res_d.alive             = 1'b0;
		res_d.status            = gha_pkg::STATUS_OK;
		case (item_s1.kind)
			gha_pkg::KIND_CREATE: begin
				if (reuse) begin
					we                      = 1'b1;
					wr_addr                 = IW'(free_head_q);
					wr_link                 = free_head_q;
					wr_gen                  = next_gen;
					res_d.result_index      = gha_pkg::IDX_W'(free_head_q);
					res_d.result_generation = gha_pkg::GEN_W'(next_gen);
				end else if (used_q < NONE) begin
					we                      = 1'b1;
					wr_addr                 = IW'(used_q);
					wr_link                 = used_q;
					wr_gen                  = '0;
					res_d.result_index      = gha_pkg::IDX_W'(used_q);
					res_d.result_generation = '0;
				end else begin
					res_d.status = gha_pkg::STATUS_FULL;
				end
			end
			gha_pkg::KIND_REMOVE: begin
				if (alive) begin
					we          = 1'b1;
					wr_link     = (free_cnt_q != '0) ? free_head_q : NONE;
					res_d.alive = 1'b1;
				end else begin
					res_d.status = gha_pkg::STATUS_STALE;
				end
			end
			gha_pkg::KIND_QUERY: begin
				res_d.alive = alive;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && we) begin
			link_mem[wr_addr] <= wr_link;
			gen_mem[wr_addr]  <= wr_gen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			free_head_q <= NONE;
			free_cnt_q  <= '0;
		end else if (cmd.exec) begin
			case (item_s1.kind)
				gha_pkg::KIND_CREATE: begin
					if (reuse) begin
						free_head_q <= rd_link_s1;
						free_cnt_q  <= free_cnt_q - 1'b1;
					end else if (used_q < NONE) begin
						used_q <= used_q + 1'b1;
					end
				end
				gha_pkg::KIND_REMOVE: begin
					if (alive) begin
						free_head_q <= LW'(item_s1.entity_index);
						free_cnt_q  <= free_cnt_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) result_q <= res_d;
	end

	assign result = result_q;

endmodule

>>> design/generational_handle_allocator.sv
// generational_handle_allocator: top level, joins the sequencer and the slot datapath
// depends on gha_pkg, gha_ctrl and gha_datapath
//
// An item is accepted at an edge with start high and busy low; busy is then high for one
// cycle while it holds the entry read from the synchronous slot memory at that edge, and at the next edge
// the entry is updated and the result registered. done is high with the result beat for exactly
// one cycle, and a new item can be accepted in that same cycle; no new item
// is taken while busy, since each item reads and writes a slot memory entry. done cannot be held
// off: the receiver must take every beat when it appears. No clearing pass is needed after
// reset.
module generational_handle_allocator #(
	parameter int CAPACITY = gha_pkg::DEF_CAPACITY,
	parameter int GEN_BITS = gha_pkg::DEF_GEN_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  gha_pkg::item_t   item,
	output logic             done,
	output gha_pkg::result_t result
);

	gha_pkg::ctrl_cmd_t cmd;

	gha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	gha_datapath #(
		.CAPACITY (CAPACITY),
		.GEN_BITS (GEN_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.result (result)
	);

endmodule

>>> tb/sv/gha_checker.sv
`timescale 1ns / 1ps
// gha_checker: watches the command and result beats of the handle allocator, keeps its own
// slot table to predict every result and compares each result beat; depends on gha_pkg
module gha_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  gha_pkg::item_t   item,
	input  logic             done,
	input  gha_pkg::result_t result,
	output int unsigned      error_count,
	output int unsigned      pending,
	output int unsigned      checked
);
	import gha_pkg::*;

	localparam int CAPACITY = DEF_CAPACITY;
	localparam logic [IDX_W:0] NO_SLOT = (IDX_W+1)'(CAPACITY);

	// link holds the slot's own index while alive, the next free slot (or NO_SLOT) while freed
	logic [IDX_W:0]   link_of [CAPACITY];
	logic [GEN_W-1:0] gen_of [CAPACITY];
	logic [IDX_W:0]   n_used;
	logic [IDX_W:0]   head;
	logic [IDX_W:0]   n_free;

	result_t outcomes_due [$];
	result_t want;

	function automatic bit is_live(input logic [IDX_W-1:0] idx, input logic [GEN_W-1:0] gen);
		return ({1'b0, idx} < n_used) && (link_of[idx] == {1'b0, idx}) && (gen_of[idx] == gen);
	endfunction

	function automatic result_t allocator_outcome(input item_t it);
		result_t          r;
		logic [IDX_W-1:0] slot;
		r.result_index      = it.entity_index;
		r.result_generation = it.entity_generation;
		r.alive             = 1'b0;
		r.status            = STATUS_OK;
		case (it.kind)
			KIND_CREATE: begin
				if (n_free != 0 && head < NO_SLOT) begin
					slot          = head[IDX_W-1:0];
					gen_of[slot]  = gen_of[slot] + 1'b1;
					head          = link_of[slot];
					link_of[slot] = {1'b0, slot};
					n_free        = n_free - 1'b1;
					r.result_index      = slot;
					r.result_generation = gen_of[slot];
				end else if (n_used < NO_SLOT) begin
					slot          = n_used[IDX_W-1:0];
					gen_of[slot]  = '0;
					link_of[slot] = n_used;
					n_used        = n_used + 1'b1;
					r.result_index      = slot;
					r.result_generation = '0;
				end else begin
					r.status = STATUS_FULL;
				end
			end
			KIND_REMOVE: begin
				if (is_live(it.entity_index, it.entity_generation)) begin
					r.alive = 1'b1;
					link_of[it.entity_index] = (n_free != 0) ? head : NO_SLOT;
					head   = {1'b0, it.entity_index};
					n_free = n_free + 1'b1;
				end else begin
					r.status = STATUS_STALE;
				end
			end
			KIND_QUERY: begin
				r.alive = is_live(it.entity_index, it.entity_generation);
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			n_used = '0;
			head   = NO_SLOT;
			n_free = '0;
			outcomes_due.delete();
			error_count = 0;
			pending     = 0;
			checked     = 0;
		end else begin
			// retire the result beat first: it belongs to an item taken earlier
			if (done) begin
				if (outcomes_due.size() == 0) begin
					$display("%0t: extra beat: expected none, got %0d/%0d alive %0b status %0d",
						$time, result.result_index, result.result_generation, result.alive,
						result.status);
					error_count++;
				end else begin
					want = outcomes_due.pop_front();
					checked++;
					if (result !== want) begin
						$display("%0t: mismatch: expected idx %0d gen %0d alive %0b status %0d",
							$time, want.result_index, want.result_generation, want.alive,
							want.status);
						$display("%0t:           actual   idx %0d gen %0d alive %0b status %0d",
							$time, result.result_index, result.result_generation, result.alive,
							result.status);
						error_count++;
					end
				end
			end
			if (start && !busy)
				outcomes_due.push_back(allocator_outcome(item));
			pending = outcomes_due.size();
		end
	end

endmodule

>>> tb/sv/tb_generational_handle_allocator.sv
`timescale 1ns / 1ps
// tb_generational_handle_allocator: drives command beats into the handle allocator and gives
// the verdict; depends on gha_pkg, gha_checker and the allocator rtl
module tb_generational_handle_allocator;
	import gha_pkg::*;

	localparam logic [1:0] KIND_NOP = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DEAD_KEEP = 32;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [GEN_W-1:0] gen;
	} handle_t;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    done;
	result_t result;

	int unsigned error_count;
	int unsigned pending;
	int unsigned checked;

	int unsigned idle_pct     = 7;
	int unsigned stall_cycles = 0;
	int unsigned n_kind [4];
	int unsigned n_full = 0;

	logic [1:0] kinds_in_flight [$];
	logic [1:0] done_kind;
	handle_t    live_pool [$];
	handle_t    dead_pool [$];

	always #1 clk = ~clk;

	generational_handle_allocator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	gha_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.done        (done),
		.result      (result),
		.error_count (error_count),
		.pending     (pending),
		.checked     (checked)
	);

	// harvest fresh handles from create results so later beats can aim at live slots
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= (done || (start && !busy)) ? 0 : stall_cycles + 1;
			if (done && kinds_in_flight.size() != 0) begin
				done_kind = kinds_in_flight.pop_front();
				if (done_kind == KIND_CREATE && result.status == STATUS_OK)
					live_pool.push_back({result.result_index, result.result_generation});
				if (result.status == STATUS_FULL)
					n_full++;
			end
			if (start && !busy) begin
				kinds_in_flight.push_back(item.kind);
				n_kind[item.kind]++;
			end
		end
	end

	function automatic logic [IDX_W-1:0] rand_idx();
		return IDX_W'($urandom);
	endfunction

	function automatic logic [GEN_W-1:0] rand_gen();
		return GEN_W'($urandom);
	endfunction

	task automatic send_beat(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
		input logic [GEN_W-1:0] gen);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			item  <= item_t'($urandom);
			@(negedge clk);
		end
		start <= 1'b1;
		item  <= '{kind: kind, entity_index: idx, entity_generation: gen};
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic random_op();
		int unsigned roll;
		int unsigned pos;
		handle_t     h;
		roll = $urandom_range(0, 99);
		if (live_pool.size() == 0 || roll < 35) begin
			send_beat(KIND_CREATE, rand_idx(), rand_gen());
		end else if (roll < 60) begin
			pos = $urandom_range(0, live_pool.size() - 1);
			h   = live_pool[pos];
			live_pool.delete(pos);
			if (dead_pool.size() >= DEAD_KEEP)
				void'(dead_pool.pop_front());
			dead_pool.push_back(h);
			send_beat(KIND_REMOVE, h.idx, h.gen);
		end else if (roll < 78) begin
			h = live_pool[$urandom_range(0, live_pool.size() - 1)];
			send_beat(KIND_QUERY, h.idx, h.gen);
		end else if (roll < 86 && dead_pool.size() != 0) begin
			// stale handle: right slot, retired generation
			h = dead_pool[$urandom_range(0, dead_pool.size() - 1)];
			send_beat(roll[0] ? KIND_REMOVE : KIND_QUERY, h.idx, h.gen);
		end else if (roll < 94) begin
			send_beat(2'($urandom_range(KIND_REMOVE, KIND_QUERY)), rand_idx(), rand_gen());
		end else begin
			send_beat(KIND_NOP, rand_idx(), rand_gen());
		end
	endtask

	initial begin
		while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("[generational_handle_allocator] ERROR");
		$finish;
	end

	initial begin
		handle_t h;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty table, fresh slots, stale handles, free list reuse, unused kind
		send_beat(KIND_QUERY,  '0, '0);
		send_beat(KIND_REMOVE, '0, '0);
		send_beat(KIND_CREATE, '0, '0);
		send_beat(KIND_CREATE, '1, '1);
		send_beat(KIND_QUERY,  10'd0, 8'd0);
		send_beat(KIND_QUERY,  10'd0, 8'd1);
		send_beat(KIND_QUERY,  '1, '1);
		send_beat(KIND_REMOVE, 10'd1, 8'd0);
		send_beat(KIND_REMOVE, 10'd1, 8'd0);
		send_beat(KIND_QUERY,  10'd1, 8'd0);
		send_beat(KIND_REMOVE, 10'd0, 8'd0);
		send_beat(KIND_CREATE, '0, '0);
		send_beat(KIND_CREATE, '0, '0);
		send_beat(KIND_CREATE, '1, '1);
		send_beat(KIND_NOP,    '1, '1);
		send_beat(KIND_NOP,    '0, '0);
		send_beat(KIND_REMOVE, 10'd2, '1);
		send_beat(KIND_QUERY,  10'd0, 8'd1);
		drain();
		// the first two handles were removed above
		for (int n = live_pool.size() - 1; n >= 0; n--)
			if (live_pool[n].idx <= 1 && live_pool[n].gen == 0)
				live_pool.delete(n);

		repeat (70) random_op();
		drain();

		// hammer one slot through remove and reuse until its generation wraps
		idle_pct = 48;
		if (live_pool.size() == 0) begin
			send_beat(KIND_CREATE, '0, '0);
			drain();
		end
		h = live_pool.pop_back();
		for (int r = 0; r < 258; r++) begin
			send_beat(KIND_REMOVE, h.idx, h.gen);
			if ($urandom_range(0, 3) == 0)
				send_beat(KIND_QUERY, h.idx, h.gen);
			send_beat(KIND_CREATE, rand_idx(), rand_gen());
			drain();
			if (live_pool.size() == 0)
				break;
			h = live_pool.pop_back();
		end
		live_pool.push_back(h);
		repeat (40) random_op();

		// churn with no idle cycles
		idle_pct = 0;
		repeat (40) random_op();

		drain();
		repeat (6) @(posedge clk);
		$display("beats sent: %0d create, %0d remove, %0d query, %0d unused kind",
			n_kind[KIND_CREATE], n_kind[KIND_REMOVE], n_kind[KIND_QUERY], n_kind[KIND_NOP]);
		$display("%0d results checked, %0d table full, one slot wrapped, %0d mismatches",
			checked, n_full, error_count);
		if (error_count == 0)
			$display("[generational_handle_allocator] OK");
		else
			$display("[generational_handle_allocator] ERROR");
		$finish;
	end

endmodule

>>> filelist.f
design/gha_pkg.sv
design/gha_ctrl.sv
design/gha_datapath.sv
design/generational_handle_allocator.sv
tb/sv/gha_checker.sv
tb/sv/tb_generational_handle_allocator.sv
